// File: src/clock_time_field_editor_top_assert.svh
// Assertion macros for the clock time field editor.
`ifndef CLOCK_TIME_FIELD_EDITOR_TOP_ASSERT_SVH
`define CLOCK_TIME_FIELD_EDITOR_TOP_ASSERT_SVH

// Checks that post holds in the same cycle whenever pre holds.
`define CTFE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Checks that post holds in the cycle after pre holds.
`define CTFE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/ctfe_pkg.sv
// Types, codes and conversion functions for the clock time field editor.
package ctfe_pkg;

  localparam int unsigned FIELD_W = 8;

  typedef logic [2:0]         op_t;
  typedef logic [2:0]         cursor_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam op_t OP_LOAD   = 3'd0;
  localparam op_t OP_LEFT   = 3'd1;
  localparam op_t OP_RIGHT  = 3'd2;
  localparam op_t OP_INC    = 3'd3;
  localparam op_t OP_DEC    = 3'd4;
  localparam op_t OP_COMMIT = 3'd5;

  localparam cursor_t CUR_NONE   = 3'd0;
  localparam cursor_t CUR_YEAR   = 3'd1;
  localparam cursor_t CUR_MONTH  = 3'd2;
  localparam cursor_t CUR_DAY    = 3'd3;
  localparam cursor_t CUR_HOUR   = 3'd4;
  localparam cursor_t CUR_MINUTE = 3'd5;
  localparam cursor_t CUR_SECOND = 3'd6;

  typedef struct packed {
    field_t year;
    field_t month;
    field_t day;
    field_t hour;
    field_t minute;
    field_t second;
  } ctfe_fields_t;

  typedef struct packed {
    op_t    operation;
    field_t load_year_bcd;
    field_t load_month_bcd;
    field_t load_day_bcd;
    field_t load_hour_bcd;
    field_t load_minute_bcd;
    field_t load_second_bcd;
  } ctfe_item_t;

  typedef struct packed {
    cursor_t      cursor;
    ctfe_fields_t fields;
    logic         commit_valid;
    logic [47:0]  packed_bcd_time;
  } ctfe_result_t;

  function automatic field_t bcd_to_bin(input field_t b);
    return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
  endfunction

  function automatic field_t bin_to_bcd(input field_t v);
    logic [6:0]  r;
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    if (v >= 8'd200) begin
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      r = 7'(v - 8'd100);
    end else begin
      r = v[6:0];
    end
    prod = 14'(r) * 14'd103;
    tens = prod[13:10];
    ones = r - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
    return {tens, ones[3:0]};
  endfunction

  function automatic field_t day_limit(input field_t month);
    field_t lim;
    case (month)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: lim = 8'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    lim = 8'd30;
      8'd2:                                       lim = 8'd28;
      default:                                    lim = 8'd0;
    endcase
    return lim;
  endfunction

endpackage

// File: src/ctfe_if.sv
// Valid and ready channel interfaces for the input and result beats.
interface ctfe_in_if;
  import ctfe_pkg::*;
  logic   valid;
  logic   ready;
  op_t    operation;
  field_t load_year_bcd;
  field_t load_month_bcd;
  field_t load_day_bcd;
  field_t load_hour_bcd;
  field_t load_minute_bcd;
  field_t load_second_bcd;

  modport source (
    output valid, operation, load_year_bcd, load_month_bcd, load_day_bcd,
    output load_hour_bcd, load_minute_bcd, load_second_bcd,
    input  ready
  );
  modport sink (
    input  valid, operation, load_year_bcd, load_month_bcd, load_day_bcd,
    input  load_hour_bcd, load_minute_bcd, load_second_bcd,
    output ready
  );
endinterface

interface ctfe_out_if;
  import ctfe_pkg::*;
  logic        valid;
  logic        ready;
  cursor_t     cursor;
  field_t      year_value;
  field_t      month_value;
  field_t      day_value;
  field_t      hour_value;
  field_t      minute_value;
  field_t      second_value;
  logic        commit_valid;
  logic [47:0] packed_bcd_time;

  modport source (
    output valid, cursor, year_value, month_value, day_value, hour_value,
    output minute_value, second_value, commit_valid, packed_bcd_time,
    input  ready
  );
  modport sink (
    input  valid, cursor, year_value, month_value, day_value, hour_value,
    input  minute_value, second_value, commit_valid, packed_bcd_time,
    output ready
  );
endinterface

// File: src/ctfe_edit.sv
// Combinational edit of the cursor and time fields for one input beat.
module ctfe_edit (
  input  ctfe_pkg::ctfe_item_t   item,
  input  ctfe_pkg::cursor_t      cursor,
  input  ctfe_pkg::ctfe_fields_t fields,
  output ctfe_pkg::ctfe_result_t result
);
  import ctfe_pkg::*;

  field_t     old_val;
  field_t     dec_val;
  field_t     new_val;
  field_t     lim;
  logic [8:0] inc_val;
  logic       is_dec;

  always_comb begin
    case (cursor)
      CUR_YEAR:   old_val = fields.year;
      CUR_MONTH:  old_val = fields.month;
      CUR_DAY:    old_val = fields.day;
      CUR_HOUR:   old_val = fields.hour;
      CUR_MINUTE: old_val = fields.minute;
      CUR_SECOND: old_val = fields.second;
      default:    old_val = '0;
    endcase
  end

  assign lim     = day_limit(fields.month);
  assign inc_val = {1'b0, old_val} + 9'd1;
  assign dec_val = old_val - 8'd1;
  assign is_dec  = (item.operation == OP_DEC);

  always_comb begin
    new_val = old_val;
    case (cursor)
      CUR_YEAR: begin
        if (is_dec) begin
          new_val = (old_val == 8'd0 || dec_val > 8'd99) ? 8'd99 : dec_val;
        end else begin
          new_val = (inc_val > 9'd99) ? 8'd0 : inc_val[7:0];
        end
      end
      CUR_MONTH: begin
        if (is_dec) begin
          new_val = (dec_val == 8'd0 || dec_val > 8'd12) ? 8'd12 : dec_val;
        end else begin
          new_val = (inc_val > 9'd12) ? 8'd1 : inc_val[7:0];
        end
      end
      CUR_DAY: begin
        if (is_dec) begin
          new_val = (lim != 8'd0 && old_val == 8'd1) ? lim : dec_val;
        end else begin
          new_val = (lim != 8'd0 && inc_val > {1'b0, lim}) ? 8'd1 : inc_val[7:0];
        end
      end
      CUR_HOUR: begin
        if (is_dec) begin
          new_val = (dec_val > 8'd23) ? 8'd23 : dec_val;
        end else begin
          new_val = (inc_val > 9'd23) ? 8'd0 : inc_val[7:0];
        end
      end
      CUR_MINUTE, CUR_SECOND: begin
        if (is_dec) begin
          new_val = (dec_val > 8'd59) ? 8'd59 : dec_val;
        end else begin
          new_val = (inc_val > 9'd59) ? 8'd0 : inc_val[7:0];
        end
      end
      default: new_val = old_val;
    endcase
  end

  always_comb begin
    result.cursor          = cursor;
    result.fields          = fields;
    result.commit_valid    = 1'b0;
    result.packed_bcd_time = '0;
    case (item.operation)
      OP_LOAD: begin
        result.fields.year   = bcd_to_bin(item.load_year_bcd);
        result.fields.month  = bcd_to_bin(item.load_month_bcd);
        result.fields.day    = bcd_to_bin(item.load_day_bcd);
        result.fields.hour   = bcd_to_bin(item.load_hour_bcd);
        result.fields.minute = bcd_to_bin(item.load_minute_bcd);
        result.fields.second = bcd_to_bin(item.load_second_bcd);
      end
      OP_LEFT: begin
        result.cursor = (cursor <= CUR_YEAR) ? CUR_SECOND : cursor - 3'd1;
      end
      OP_RIGHT: begin
        result.cursor = (cursor == CUR_NONE || cursor >= CUR_SECOND) ?
                        CUR_YEAR : cursor + 3'd1;
      end
      OP_INC, OP_DEC: begin
        case (cursor)
          CUR_YEAR:   result.fields.year   = new_val;
          CUR_MONTH:  result.fields.month  = new_val;
          CUR_DAY:    result.fields.day    = new_val;
          CUR_HOUR:   result.fields.hour   = new_val;
          CUR_MINUTE: result.fields.minute = new_val;
          CUR_SECOND: result.fields.second = new_val;
          default:    result.fields        = fields;
        endcase
      end
      OP_COMMIT: begin
        result.commit_valid    = 1'b1;
        result.packed_bcd_time = {bin_to_bcd(fields.year), bin_to_bcd(fields.month),
                                  bin_to_bcd(fields.day), bin_to_bcd(fields.hour),
                                  bin_to_bcd(fields.minute), bin_to_bcd(fields.second)};
      end
      default: result.commit_valid = 1'b0;
    endcase
  end

endmodule

// File: src/clock_time_field_editor_top.sv
// Top level of the clock time field editor: input register, edit logic, result register.
// A beat moves from the input register through the edit logic into the result register.
// Throughput: one beat per cycle, set by the single edit pass, unless out_ch.ready stalls it.
// Reset: synchronous active-low rst_n clears the cursor, all six fields and both valid flags.
`include "clock_time_field_editor_top_assert.svh"
module clock_time_field_editor_top (
  input logic        clk,
  input logic        rst_n,
  ctfe_in_if.sink    in_ch,
  ctfe_out_if.source out_ch
);
  import ctfe_pkg::*;

  ctfe_item_t   item_r;
  logic         item_valid_r;
  cursor_t      cursor_r;
  ctfe_fields_t fields_r;
  ctfe_result_t res_r;
  logic         res_valid_r;
  ctfe_result_t res_nxt;
  logic         adv;

  assign adv         = item_valid_r && (!res_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || adv;

  ctfe_edit u_edit (
    .item   (item_r),
    .cursor (cursor_r),
    .fields (fields_r),
    .result (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.operation       <= in_ch.operation;
      item_r.load_year_bcd   <= in_ch.load_year_bcd;
      item_r.load_month_bcd  <= in_ch.load_month_bcd;
      item_r.load_day_bcd    <= in_ch.load_day_bcd;
      item_r.load_hour_bcd   <= in_ch.load_hour_bcd;
      item_r.load_minute_bcd <= in_ch.load_minute_bcd;
      item_r.load_second_bcd <= in_ch.load_second_bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= CUR_NONE;
      fields_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        cursor_r    <= res_nxt.cursor;
        fields_r    <= res_nxt.fields;
        res_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = res_valid_r;
  assign out_ch.cursor          = res_r.cursor;
  assign out_ch.year_value      = res_r.fields.year;
  assign out_ch.month_value     = res_r.fields.month;
  assign out_ch.day_value       = res_r.fields.day;
  assign out_ch.hour_value      = res_r.fields.hour;
  assign out_ch.minute_value    = res_r.fields.minute;
  assign out_ch.second_value    = res_r.fields.second;
  assign out_ch.commit_valid    = res_r.commit_valid;
  assign out_ch.packed_bcd_time = res_r.packed_bcd_time;

  // The cursor never leaves the range from no field to the second field.
  `CTFE_ASSERT_NOW(a_cursor_range, 1'b1, cursor_r <= CUR_SECOND, "cursor out of range")
  // A beat that moves into the result register makes the result valid.
  `CTFE_ASSERT_NEXT(a_adv_fills_result, adv, res_valid_r, "result lost after advance")
  // The held state changes only when a beat passes through the edit logic.
  `CTFE_ASSERT_NEXT(a_state_holds, !adv, $stable(cursor_r) && $stable(fields_r),
                    "state changed without a beat")
  // A waiting beat in the input register is neither dropped nor overwritten.
  `CTFE_ASSERT_NEXT(a_item_holds, item_valid_r && !adv, item_valid_r && $stable(item_r),
                    "waiting input beat disturbed")

endmodule

// File: dv/clock_time_field_editor_top_tb.sv
// Self-checking testbench for the clock time field editor: directed edits, then random edit sequences.
module clock_time_field_editor_top_tb;
  import ctfe_pkg::*;

  localparam op_t         OP_SPARE6      = 3'd6;
  localparam op_t         OP_SPARE7      = 3'd7;
  localparam int unsigned RANDOM_BEATS   = 550;
  localparam int unsigned BURST_BEATS    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 4;

  logic clk;
  logic rst_n;

  ctfe_in_if  in_ch ();
  ctfe_out_if out_ch ();

  clock_time_field_editor_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cursor_t      sel_field;
  field_t       clock_fields [CUR_YEAR:CUR_SECOND];
  ctfe_result_t expected_views [$];
  int unsigned  beats_sent;
  int unsigned  mismatches;
  bit           idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic field_t bcd_byte_to_bin(input field_t b);
    return field_t'(b[7:4] * 10 + b[3:0]);
  endfunction

  function automatic field_t bin_to_bcd_byte(input field_t v);
    int unsigned r;
    r = v % 100;
    return field_t'(((r / 10) << 4) | (r % 10));
  endfunction

  function automatic int unsigned month_day_count(input field_t month);
    case (month)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: return 31;
      8'd4, 8'd6, 8'd9, 8'd11:                    return 30;
      8'd2:                                       return 28;
      default:                                    return 0;
    endcase
  endfunction

  // Applies one beat to the model state and returns the view the block should report.
  function automatic ctfe_result_t edit_clock(input ctfe_item_t it);
    ctfe_result_t view;
    int unsigned  v;
    int unsigned  lim;
    field_t       old;
    view = '0;
    case (it.operation)
      OP_LOAD: begin
        clock_fields[CUR_YEAR]   = bcd_byte_to_bin(it.load_year_bcd);
        clock_fields[CUR_MONTH]  = bcd_byte_to_bin(it.load_month_bcd);
        clock_fields[CUR_DAY]    = bcd_byte_to_bin(it.load_day_bcd);
        clock_fields[CUR_HOUR]   = bcd_byte_to_bin(it.load_hour_bcd);
        clock_fields[CUR_MINUTE] = bcd_byte_to_bin(it.load_minute_bcd);
        clock_fields[CUR_SECOND] = bcd_byte_to_bin(it.load_second_bcd);
      end
      OP_LEFT: begin
        sel_field = (sel_field <= CUR_YEAR) ? CUR_SECOND : cursor_t'(sel_field - 1);
      end
      OP_RIGHT: begin
        sel_field = (sel_field == CUR_NONE || sel_field >= CUR_SECOND) ? CUR_YEAR :
                    cursor_t'(sel_field + 1);
      end
      OP_INC: begin
        if (sel_field != CUR_NONE) begin
          v = clock_fields[sel_field] + 1;
          case (sel_field)
            CUR_YEAR:  if (v > 99) v = 0;
            CUR_MONTH: if (v > 12) v = 1;
            CUR_DAY: begin
              lim = month_day_count(clock_fields[CUR_MONTH]);
              if (lim != 0 && v > lim) v = 1;
            end
            CUR_HOUR:  if (v > 23) v = 0;
            default:   if (v > 59) v = 0;
          endcase
          clock_fields[sel_field] = field_t'(v);
        end
      end
      OP_DEC: begin
        if (sel_field != CUR_NONE) begin
          old = clock_fields[sel_field];
          v   = field_t'(old - 1);
          case (sel_field)
            CUR_YEAR:  if (old == 0 || v > 99) v = 99;
            CUR_MONTH: if (v == 0 || v > 12) v = 12;
            CUR_DAY: begin
              lim = month_day_count(clock_fields[CUR_MONTH]);
              if (lim != 0 && old == 1) v = lim;
            end
            CUR_HOUR:  if (v > 23) v = 23;
            default:   if (v > 59) v = 59;
          endcase
          clock_fields[sel_field] = field_t'(v);
        end
      end
      OP_COMMIT: begin
        view.commit_valid    = 1'b1;
        view.packed_bcd_time = {bin_to_bcd_byte(clock_fields[CUR_YEAR]),
                                bin_to_bcd_byte(clock_fields[CUR_MONTH]),
                                bin_to_bcd_byte(clock_fields[CUR_DAY]),
                                bin_to_bcd_byte(clock_fields[CUR_HOUR]),
                                bin_to_bcd_byte(clock_fields[CUR_MINUTE]),
                                bin_to_bcd_byte(clock_fields[CUR_SECOND])};
      end
      default: begin
      end
    endcase
    view.cursor        = sel_field;
    view.fields.year   = clock_fields[CUR_YEAR];
    view.fields.month  = clock_fields[CUR_MONTH];
    view.fields.day    = clock_fields[CUR_DAY];
    view.fields.hour   = clock_fields[CUR_HOUR];
    view.fields.minute = clock_fields[CUR_MINUTE];
    view.fields.second = clock_fields[CUR_SECOND];
    return view;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_edge(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic ctfe_item_t random_item(input op_t op);
    ctfe_item_t it;
    it.operation       = op;
    it.load_year_bcd   = field_t'($urandom);
    it.load_month_bcd  = field_t'($urandom);
    it.load_day_bcd    = field_t'($urandom);
    it.load_hour_bcd   = field_t'($urandom);
    it.load_minute_bcd = field_t'($urandom);
    it.load_second_bcd = field_t'($urandom);
    return it;
  endfunction

  // Mostly legal dates and times, biased towards the ends of each range.
  function automatic ctfe_item_t random_load();
    ctfe_item_t  it;
    int unsigned month;
    it = random_item(OP_LOAD);
    if ($urandom_range(0, 99) < 15) return it;
    month              = pick_edge(1, 12);
    it.load_year_bcd   = bin_to_bcd_byte(field_t'(pick_edge(0, 99)));
    if ($urandom_range(0, 9) != 0) it.load_month_bcd = bin_to_bcd_byte(field_t'(month));
    it.load_day_bcd    = bin_to_bcd_byte(field_t'(pick_edge(1,
                                         month_day_count(field_t'(month)))));
    it.load_hour_bcd   = bin_to_bcd_byte(field_t'(pick_edge(0, 23)));
    it.load_minute_bcd = bin_to_bcd_byte(field_t'(pick_edge(0, 59)));
    it.load_second_bcd = bin_to_bcd_byte(field_t'(pick_edge(0, 59)));
    return it;
  endfunction

  task automatic send_beat(input ctfe_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= it.operation;
    in_ch.load_year_bcd   <= it.load_year_bcd;
    in_ch.load_month_bcd  <= it.load_month_bcd;
    in_ch.load_day_bcd    <= it.load_day_bcd;
    in_ch.load_hour_bcd   <= it.load_hour_bcd;
    in_ch.load_minute_bcd <= it.load_minute_bcd;
    in_ch.load_second_bcd <= it.load_second_bcd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_views.push_back(edit_clock(it));
    beats_sent++;
  endtask

  task automatic send_op(input op_t op);
    send_beat(random_item(op));
  endtask

  task automatic send_load(input field_t y, input field_t mo, input field_t d,
                           input field_t h, input field_t mi, input field_t s);
    ctfe_item_t it;
    it = '{OP_LOAD, y, mo, d, h, mi, s};
    send_beat(it);
  endtask

  task automatic select_field(input cursor_t target, input bit go_left);
    while (sel_field != target) send_op(go_left ? OP_LEFT : OP_RIGHT);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
  endtask

  task automatic random_sequence();
    int unsigned edits;
    int unsigned steps;
    op_t         dir;
    if ($urandom_range(0, 99) < 15) begin
      send_op(op_t'($urandom_range(OP_LOAD, OP_SPARE7)));
      return;
    end
    send_beat(random_load());
    edits = $urandom_range(1, 4);
    repeat (edits) begin
      select_field(cursor_t'($urandom_range(CUR_YEAR, CUR_SECOND)),
                   1'($urandom_range(0, 1)));
      dir   = $urandom_range(0, 1) ? OP_INC : OP_DEC;
      steps = $urandom_range(1, 6);
      repeat (steps) send_op(dir);
    end
    if ($urandom_range(0, 9) < 7) send_op(OP_COMMIT);
  endtask

  task automatic test_no_selection();
    send_op(OP_INC);
    send_op(OP_DEC);
    send_op(OP_COMMIT);
    send_op(OP_SPARE6);
    send_op(OP_SPARE7);
  endtask

  task automatic test_wraparound();
    send_load(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);
    send_op(OP_LEFT);
    send_op(OP_INC);
    select_field(CUR_HOUR, 1'b1);
    send_op(OP_INC);
    select_field(CUR_DAY, 1'b1);
    send_op(OP_INC);
    select_field(CUR_MONTH, 1'b1);
    send_op(OP_INC);
    select_field(CUR_YEAR, 1'b1);
    send_op(OP_INC);
    send_op(OP_LEFT);
    send_op(OP_RIGHT);
    send_op(OP_DEC);
    select_field(CUR_MONTH, 1'b0);
    send_op(OP_DEC);
    select_field(CUR_DAY, 1'b0);
    send_op(OP_DEC);
    send_op(OP_COMMIT);
  endtask

  // Non-decimal digits, a month of zero and a day that counts freely across the wrap between 0 and 255.
  task automatic test_invalid_bcd();
    send_load(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_COMMIT);
    select_field(CUR_DAY, 1'b0);
    send_op(OP_DEC);
    send_op(OP_INC);
    select_field(CUR_YEAR, 1'b1);
    send_op(OP_DEC);
  endtask

  task automatic test_back_to_back();
    int unsigned stop_at;
    stop_at = beats_sent + BURST_BEATS;
    idle_on = 1'b0;
    while (beats_sent < stop_at) random_sequence();
    idle_on = 1'b1;
  endtask

  task automatic test_random_edits(input int unsigned stop_at);
    while (beats_sent < stop_at) random_sequence();
  endtask

  function automatic void compare_field(input string name, input logic [47:0] want,
                                        input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    ctfe_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_views.size() == 0) begin
        $error("result beat with none expected: cursor %0d", out_ch.cursor);
        mismatches++;
      end else begin
        want = expected_views.pop_front();
        compare_field("cursor", 48'(want.cursor), 48'(out_ch.cursor));
        compare_field("year_value", 48'(want.fields.year), 48'(out_ch.year_value));
        compare_field("month_value", 48'(want.fields.month), 48'(out_ch.month_value));
        compare_field("day_value", 48'(want.fields.day), 48'(out_ch.day_value));
        compare_field("hour_value", 48'(want.fields.hour), 48'(out_ch.hour_value));
        compare_field("minute_value", 48'(want.fields.minute), 48'(out_ch.minute_value));
        compare_field("second_value", 48'(want.fields.second), 48'(out_ch.second_value));
        compare_field("commit_valid", 48'(want.commit_valid), 48'(out_ch.commit_valid));
        compare_field("packed_bcd_time", want.packed_bcd_time, out_ch.packed_bcd_time);
      end
    end
  end

  initial begin : result_stall
    int unsigned run;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[clock_time_field_editor_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_end;
    idle_on    = 1'b1;
    beats_sent = 0;
    mismatches = 0;
    sel_field  = CUR_NONE;
    foreach (clock_fields[i]) clock_fields[i] = '0;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.operation       <= OP_LOAD;
    in_ch.load_year_bcd   <= '0;
    in_ch.load_month_bcd  <= '0;
    in_ch.load_day_bcd    <= '0;
    in_ch.load_hour_bcd   <= '0;
    in_ch.load_minute_bcd <= '0;
    in_ch.load_second_bcd <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_no_selection();
    test_wraparound();
    test_invalid_bcd();
    wait_for_results();

    random_end = beats_sent + RANDOM_BEATS;
    test_back_to_back();
    test_random_edits(random_end);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("[clock_time_field_editor_top] OK");
    end else begin
      $display("[clock_time_field_editor_top] ERROR");
    end
    $finish;
  end

endmodule
